// ===== hw/rtl/lhc_pkg.sv =====
// Package for the file-handle LRU cache: payload types, scan status type and FSM states.
package lhc_pkg;

  // Default geometry of the cache.
  localparam int unsigned DefSlots     = 8;
  localparam int unsigned DefStampBits = 32;

  // Widest slot index that the SLOTS range can need (up to 64 slots).
  localparam int unsigned IdxMaxW = 6;

  // Request kinds.
  localparam logic KindAcquire = 1'b0;
  localparam logic KindClear   = 1'b1;

  // One request beat.
  typedef struct packed {
    logic        kind;
    logic [31:0] file_key;
    logic        open_ok;
  } lhc_req_t;

  // One response beat.
  typedef struct packed {
    logic        hit;
    logic        found;
    logic [2:0]  slot;
    logic        evicted;
    logic [31:0] evicted_key;
  } lhc_rsp_t;

  // Outcome of a scan over all slots.
  typedef struct packed {
    logic               hit;
    logic [IdxMaxW-1:0] hit_idx;
    logic [IdxMaxW-1:0] vic_idx;
    logic               vic_empty;
    logic [31:0]        vic_key;
  } lhc_scan_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } lhc_state_e;

endpackage

// ===== hw/rtl/lhc_mem.sv =====
// Single-port-write, single-port-read slot memory with registered read data.
module lhc_mem #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3,
  parameter int unsigned Width = 64
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lhc_scan.sv =====
// Scan unit: walks the slot read data in index order and tracks the hit and the victim.
module lhc_scan #(
  parameter int unsigned StampBits = lhc_pkg::DefStampBits,
  parameter int unsigned IdxW      = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_vld_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  input  logic                  slot_vld_i,
  input  logic [31:0]           rd_key_i,
  input  logic [StampBits-1:0]  rd_stamp_i,
  input  logic [31:0]           req_key_i,
  output lhc_pkg::lhc_scan_t    scan_o
);

  logic                 hit_q, hit_d;
  logic [IdxW-1:0]      hit_idx_q, hit_idx_d;
  logic [IdxW-1:0]      vic_idx_q, vic_idx_d;
  logic                 vic_empty_q, vic_empty_d;
  logic [31:0]          vic_key_q, vic_key_d;
  logic [StampBits-1:0] vic_stamp_q, vic_stamp_d;
  logic                 first;
  logic                 hit_cur;
  logic                 match;

  assign first   = (rd_idx_i == '0);
  assign hit_cur = first ? 1'b0 : hit_q;
  assign match   = slot_vld_i && (rd_key_i == req_key_i);

  // Hit and victim tracking; slot zero restarts the scan.
  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    vic_idx_d   = vic_idx_q;
    vic_empty_d = vic_empty_q;
    vic_key_d   = vic_key_q;
    vic_stamp_d = vic_stamp_q;
    if (rd_vld_i) begin
      hit_d = hit_cur || match;
      if (!hit_cur && match) begin
        hit_idx_d = rd_idx_i;
      end
      if (first) begin
        vic_idx_d   = '0;
        vic_empty_d = !slot_vld_i;
        vic_key_d   = rd_key_i;
        vic_stamp_d = rd_stamp_i;
      end else if (!slot_vld_i) begin
        // The highest-index empty slot wins.
        vic_idx_d   = rd_idx_i;
        vic_empty_d = 1'b1;
      end else if (!vic_empty_q && (rd_stamp_i < vic_stamp_q)) begin
        // Oldest stamp wins; ties keep the lower index.
        vic_idx_d   = rd_idx_i;
        vic_key_d   = rd_key_i;
        vic_stamp_d = rd_stamp_i;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      vic_empty_q <= 1'b0;
    end else begin
      hit_q       <= hit_d;
      vic_empty_q <= vic_empty_d;
    end
  end

  // Tracked indexes, key and stamp.
  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    vic_idx_q   <= vic_idx_d;
    vic_key_q   <= vic_key_d;
    vic_stamp_q <= vic_stamp_d;
  end

  assign scan_o.hit       = hit_q;
  assign scan_o.hit_idx   = lhc_pkg::IdxMaxW'(hit_idx_q);
  assign scan_o.vic_idx   = lhc_pkg::IdxMaxW'(vic_idx_q);
  assign scan_o.vic_empty = vic_empty_q;
  assign scan_o.vic_key   = vic_key_q;

endmodule

// ===== hw/rtl/lru_handle_cache_top.sv =====
// Top level of the file-handle LRU cache: controller, valid bits, use counter and output register.
//
// A fully associative cache of SLOTS entries keyed by a 32-bit file identifier.
// Request channel: in_valid_i / in_stall_o carry one lhc_req_t beat. An acquire
// looks the key up, refreshes its stamp on a hit, or replaces a victim on a miss
// (highest-index empty slot, else the oldest stamp). A clear empties all slots.
// Response channel: out_valid_o / out_stall_i carry one lhc_rsp_t beat per request.
// Keys and stamps live in one memory with a registered read; valid bits and the
// use counter are flip-flops.
// An acquire reads every slot in turn through the single memory read port in the
// scan state, writes the slot in the update state and loads the response register
// in the response state. A new request is taken only once the response register
// has been loaded, so a stalled receiver can hold it back.
// A clear takes effect at its request beat; its all-zero response is then loaded
// in the response state, and the next request is taken once it has been loaded.
// Reset clears all valid bits and the use counter; no memory sweep is needed.
// While the receiver stalls, the response register holds its beat and a new
// request may still be taken and processed up to its own response.
module lru_handle_cache_top #(
  parameter int unsigned SLOTS      = lhc_pkg::DefSlots,
  parameter int unsigned STAMP_BITS = lhc_pkg::DefStampBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lhc_pkg::lhc_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lhc_pkg::lhc_rsp_t out_rsp_o
);

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned DataW = 32 + STAMP_BITS;

  lhc_pkg::lhc_state_e state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  rd_vld_q;
  logic [IdxW-1:0]       rd_idx_q;
  lhc_pkg::lhc_req_t     req_q;
  logic [SLOTS-1:0]      valid_q, valid_d;
  logic [STAMP_BITS-1:0] ctr_q, ctr_d;
  lhc_pkg::lhc_rsp_t     rsp_q, rsp_d;
  logic                  out_valid_q, out_valid_d;
  lhc_pkg::lhc_rsp_t     out_rsp_q;

  logic                  in_acc;
  logic                  rd_en;
  logic                  out_load;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [DataW-1:0]      mem_wdata;
  logic [DataW-1:0]      mem_rdata;
  logic [STAMP_BITS-1:0] ctr_inc;
  lhc_pkg::lhc_scan_t    scan;
  logic [IdxW-1:0]       hit_idx;
  logic [IdxW-1:0]       vic_idx;
  logic [IdxW+2:0]       slot_ext;

  assign in_stall_o = (state_q != lhc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ctr_inc    = ctr_q + STAMP_BITS'(1);
  assign hit_idx    = scan.hit_idx[IdxW-1:0];
  assign vic_idx    = scan.vic_idx[IdxW-1:0];

  // Slot memory: key in the upper bits, stamp in the lower bits.
  lhc_mem #(
    .Depth (SLOTS),
    .AddrW (IdxW),
    .Width (DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Hit and victim search over the read data.
  lhc_scan #(
    .StampBits (STAMP_BITS),
    .IdxW      (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_vld_i   (rd_vld_q),
    .rd_idx_i   (rd_idx_q),
    .slot_vld_i (valid_q[rd_idx_q]),
    .rd_key_i   (mem_rdata[DataW-1:STAMP_BITS]),
    .rd_stamp_i (mem_rdata[STAMP_BITS-1:0]),
    .req_key_i  (req_q.file_key),
    .scan_o     (scan)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lhc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_req_i.kind == lhc_pkg::KindClear) ? lhc_pkg::ST_RESP
                                                          : lhc_pkg::ST_SCAN;
        end
      end
      lhc_pkg::ST_SCAN: begin
        if (cnt_q == CntW'(SLOTS)) begin
          state_d = lhc_pkg::ST_UPDATE;
        end
      end
      lhc_pkg::ST_UPDATE: begin
        state_d = lhc_pkg::ST_RESP;
      end
      lhc_pkg::ST_RESP: begin
        if (out_load) begin
          state_d = lhc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lhc_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs: memory access, valid bits, counter and response.
  always_comb begin
    cnt_d     = cnt_q;
    valid_d   = valid_q;
    ctr_d     = ctr_q;
    rsp_d     = rsp_q;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = vic_idx;
    mem_wdata = {req_q.file_key, STAMP_BITS'(0)};
    out_load  = 1'b0;
    slot_ext  = '0;
    case (state_q)
      lhc_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_acc && (in_req_i.kind == lhc_pkg::KindClear)) begin
          valid_d = '0;
          ctr_d   = '0;
          rsp_d   = '0;
        end
      end
      lhc_pkg::ST_SCAN: begin
        rd_en = (cnt_q < CntW'(SLOTS));
        if (rd_en) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      lhc_pkg::ST_UPDATE: begin
        mem_we = 1'b1;
        rsp_d  = '0;
        if (scan.hit) begin
          // Refresh the stamp of the matching slot.
          mem_waddr   = hit_idx;
          mem_wdata   = {req_q.file_key, ctr_inc};
          ctr_d       = ctr_inc;
          slot_ext    = (IdxW + 3)'(hit_idx);
          rsp_d.hit   = 1'b1;
          rsp_d.found = 1'b1;
          rsp_d.slot  = slot_ext[2:0];
        end else begin
          // Replace the victim; it stays empty when the open fails.
          mem_waddr         = vic_idx;
          mem_wdata         = {req_q.file_key, req_q.open_ok ? ctr_inc : STAMP_BITS'(0)};
          valid_d[vic_idx]  = req_q.open_ok;
          if (req_q.open_ok) begin
            ctr_d = ctr_inc;
          end
          slot_ext          = (IdxW + 3)'(vic_idx);
          rsp_d.found       = req_q.open_ok;
          rsp_d.slot        = slot_ext[2:0];
          rsp_d.evicted     = !scan.vic_empty;
          rsp_d.evicted_key = scan.vic_empty ? 32'd0 : scan.vic_key;
        end
      end
      lhc_pkg::ST_RESP: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lhc_pkg::ST_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      valid_q     <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_en;
      valid_q     <= valid_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IdxW-1:0];
    rsp_q    <= rsp_d;
    if (in_acc) begin
      req_q <= in_req_i;
    end
    if (out_load) begin
      out_rsp_q <= rsp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== hw/rtl/lhc_checker.sv =====
// Port checker for the file-handle LRU cache and its bind to the top level.
module lhc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input lhc_pkg::lhc_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input lhc_pkg::lhc_rsp_t out_rsp_o
);

  // A request beat is followed by a busy cycle: one request in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while the previous one is still in flight");

  // A hit returns a slot and never drops an entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.hit) |->
      (out_rsp_o.found && !out_rsp_o.evicted && (out_rsp_o.evicted_key == 32'd0)))
    else $error("hit response reports an eviction or no slot");

  // Without an eviction the dropped key reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.evicted) |-> (out_rsp_o.evicted_key == 32'd0))
    else $error("evicted key nonzero without an eviction");

  // A stalled response beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled response beat changed or dropped");

endmodule

bind lru_handle_cache_top lhc_checker u_lhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
